// ===== rtl/utf8v_pkg.sv =====
// shared types and constants for the utf-8 string validator
package utf8v_pkg;

  localparam int unsigned CP_W = 21;

  // limits of the code point space
  localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_MASK    = 21'h1FF800;
  localparam logic [CP_W-1:0] SURR_BASE    = 21'h00D800;
  localparam logic [CP_W-1:0] CP2_MIN      = 21'h000080;
  localparam logic [CP_W-1:0] CP2_MAX      = 21'h0007FF;
  localparam logic [CP_W-1:0] CP3_MIN      = 21'h000800;
  localparam logic [CP_W-1:0] CP3_MAX      = 21'h00FFFF;
  localparam logic [CP_W-1:0] CP4_MIN      = 21'h010000;

  // sequence lengths
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  // register map
  localparam int unsigned     CFG_AW        = 3;
  localparam logic [CFG_AW-1:0] ADDR_ALLOW_NUL = 3'd0;

  typedef struct packed {
    logic [1:0]      bytes_pending;
    logic [2:0]      sequence_length;
    logic [CP_W-1:0] partial_code_point;
    logic            error_seen;
  } state_t;

endpackage

// ===== rtl/utf8v_cfg.sv =====
// apb-style register block holding allow_nul
module utf8v_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [utf8v_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready,
  output logic                          allow_nul
);

  logic allow_nul_r;
  logic allow_nul_nxt;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    allow_nul_nxt = allow_nul_r;
    if (wr_en && (cfg_paddr == utf8v_pkg::ADDR_ALLOW_NUL)) begin
      allow_nul_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_nul_r <= 1'b0;
    end else begin
      allow_nul_r <= allow_nul_nxt;
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr == utf8v_pkg::ADDR_ALLOW_NUL) begin
      cfg_prdata = {31'd0, allow_nul_r};
    end
  end

  assign allow_nul = allow_nul_r;

endmodule

// ===== rtl/utf8v_step.sv =====
// per-byte decode: next parser state and the result for a closing item
module utf8v_step (
  input  utf8v_pkg::state_t  st,
  input  logic               allow_nul,
  input  logic [7:0]         data_byte,
  input  logic               byte_present,
  input  logic               end_of_string,
  output utf8v_pkg::state_t  st_nxt,
  output logic               res_valid,
  output logic               res_string_valid
);

  utf8v_pkg::state_t               work;
  logic [utf8v_pkg::CP_W-1:0]      cp_sh;
  logic [1:0]                      pend_dec;
  logic                            range_bad;
  logic                            len_ok;

  assign cp_sh    = {st.partial_code_point[utf8v_pkg::CP_W-7:0], data_byte[5:0]};
  assign pend_dec = st.bytes_pending - 2'd1;
  assign range_bad = (cp_sh > utf8v_pkg::CP_MAX) ||
                     ((cp_sh & utf8v_pkg::SURR_MASK) == utf8v_pkg::SURR_BASE);

  always_comb begin
    unique case (st.sequence_length)
      utf8v_pkg::SEQ_LEN2: len_ok = ((cp_sh >= utf8v_pkg::CP2_MIN) &&
                                     (cp_sh <= utf8v_pkg::CP2_MAX)) ||
                                    ((cp_sh == '0) && allow_nul);
      utf8v_pkg::SEQ_LEN3: len_ok = (cp_sh >= utf8v_pkg::CP3_MIN) &&
                                    (cp_sh <= utf8v_pkg::CP3_MAX);
      utf8v_pkg::SEQ_LEN4: len_ok = (cp_sh >= utf8v_pkg::CP4_MIN) &&
                                    (cp_sh <= utf8v_pkg::CP_MAX);
      default:             len_ok = 1'b0;
    endcase
  end

  always_comb begin
    work = st;
    if (byte_present) begin
      if (st.bytes_pending == 2'd0) begin
        // lead byte
        priority if (!data_byte[7]) begin
          if ((data_byte == 8'h00) && !allow_nul) begin
            work = '0;
            work.error_seen = 1'b1;
          end
        end else if (data_byte[7:5] == 3'b110) begin
          work.sequence_length    = utf8v_pkg::SEQ_LEN2;
          work.partial_code_point = {16'd0, data_byte[4:0]};
          work.bytes_pending      = 2'd1;
        end else if (data_byte[7:4] == 4'b1110) begin
          work.sequence_length    = utf8v_pkg::SEQ_LEN3;
          work.partial_code_point = {17'd0, data_byte[3:0]};
          work.bytes_pending      = 2'd2;
        end else if (data_byte[7:3] == 5'b11110) begin
          work.sequence_length    = utf8v_pkg::SEQ_LEN4;
          work.partial_code_point = {18'd0, data_byte[2:0]};
          work.bytes_pending      = 2'd3;
        end else begin
          work = '0;
          work.error_seen = 1'b1;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        work = '0;
        work.error_seen = 1'b1;
      end else begin
        work.partial_code_point = cp_sh;
        work.bytes_pending      = pend_dec;
        if (pend_dec == 2'd0) begin
          // sequence complete: range, surrogate and overlong checks
          if (range_bad || !len_ok) begin
            work = '0;
            work.error_seen = 1'b1;
          end else begin
            work.sequence_length    = utf8v_pkg::SEQ_NONE;
            work.partial_code_point = '0;
          end
        end
      end
    end

    res_valid        = !byte_present || end_of_string;
    res_string_valid = !work.error_seen && (work.bytes_pending == 2'd0);
    st_nxt           = work;
    if (res_valid) begin
      st_nxt = '0;
    end
  end

endmodule

// ===== rtl/utf8_string_validator.sv =====
// top level of the streaming utf-8 string validator
//
//  channel | ports                                       | direction
//  --------+---------------------------------------------+----------
//  input   | in_valid/in_ready, data_byte, byte_present, | in
//          | end_of_string                               |
//  result  | out_valid/out_ready, out_string_valid       | out
//  config  | cfg_psel/penable/pwrite/paddr/pwdata/...    | in/out
//
// one item per cycle sustained; an item waits in the input register,
// then the decode updates the parser state and loads the result register
// a closing item's result is loaded into the result register when it leaves the input register
// synchronous active-low reset clears parser state, valids and allow_nul
// a stalled result only holds back items that close a string, and the items behind them
module utf8_string_validator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_byte_present,
  input  logic                          in_end_of_string,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_string_valid,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [utf8v_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic              allow_nul;
  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_present_r;
  logic              s1_last_r;
  utf8v_pkg::state_t st_r;
  utf8v_pkg::state_t st_nxt;
  logic              res_valid;
  logic              res_string_valid;
  logic              s1_go;
  logic              in_fire;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_string_valid_r;

  utf8v_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .allow_nul   (allow_nul)
  );

  utf8v_step u_step (
    .st               (st_r),
    .allow_nul        (allow_nul),
    .data_byte        (s1_byte_r),
    .byte_present     (s1_present_r),
    .end_of_string    (s1_last_r),
    .st_nxt           (st_nxt),
    .res_valid        (res_valid),
    .res_string_valid (res_string_valid)
  );

  // item in the input register moves on unless its result would hit a full result slot that out_ready does not empty
  assign s1_go    = s1_valid_r && (!res_valid || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r    <= in_data_byte;
      s1_present_r <= in_byte_present;
      s1_last_r    <= in_end_of_string;
    end
    if (s1_go && res_valid) begin
      out_string_valid_r <= res_string_valid;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_string_valid = out_string_valid_r;

endmodule
